FILE: hdl/hsdc_pkg.sv
// Shared widths, register indexes, constants and helpers for the saturator.
package hsdc_pkg;

  // Sample format.
  localparam int SMP_W = 24;
  localparam int FRAC  = SMP_W - 1;

  // Configuration port.
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd2;

  // Shared multiplier: signed A times unsigned B.
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

  // Shared divider: unsigned, one quotient bit per cycle.
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 27;
  localparam int DIV_CNT_W = 6;

  // Default sizes.
  localparam int CHANNELS_DEF   = 2;
  localparam int TANH_DEPTH_DEF = 256;

  // Q16 coefficients.
  localparam logic [CFG_W-1:0] Q16_ONE   = 17'd65536;
  localparam logic [15:0]      C_TANH    = 16'd45875;
  localparam logic [15:0]      C_EVEN    = 16'd19661;
  localparam logic [15:0]      C_DRV_ATT = 16'd52429;
  localparam logic [15:0]      C_POLE    = 16'd65208;

  // Saturate a wide signed value to the sample range.
  function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'((64'sd1 <<< FRAC) - 64'sd1);
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      sat_smp = hi[SMP_W-1:0];
    end else if (v < lo) begin
      sat_smp = lo[SMP_W-1:0];
    end else begin
      sat_smp = v[SMP_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/hsdc_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module hsdc_mul (
  input  logic                                clk,
  input  logic signed [hsdc_pkg::MUL_A_W-1:0] op_a,
  input  logic        [hsdc_pkg::MUL_B_W-1:0] op_b,
  output logic signed [hsdc_pkg::PROD_W-1:0]  prod_r
);

  logic signed [hsdc_pkg::PROD_W-1:0] prod_nxt;

  // One product per cycle; the sequencer picks the operands.
  assign prod_nxt = op_a * $signed({1'b0, op_b});

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: hdl/hsdc_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module hsdc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [hsdc_pkg::DIV_NUM_W-1:0]     num,
  input  logic [hsdc_pkg::DIV_DEN_W-1:0]     den,
  output logic                               busy,
  output logic [hsdc_pkg::DIV_NUM_W-1:0]     quo
);

  logic [hsdc_pkg::DIV_DEN_W-1:0] rem_r;
  logic [hsdc_pkg::DIV_DEN_W-1:0] den_r;
  logic [hsdc_pkg::DIV_NUM_W-1:0] quo_r;
  logic [hsdc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic [hsdc_pkg::DIV_DEN_W:0]   trial;
  logic [hsdc_pkg::DIV_DEN_W:0]   diff;
  logic                           ge;

  // Shift the next numerator bit into the remainder and try a subtract.
  assign trial = {rem_r, quo_r[hsdc_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= hsdc_pkg::DIV_CNT_W'(hsdc_pkg::DIV_NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == hsdc_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient share the shift; the numerator drains from the top.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[hsdc_pkg::DIV_DEN_W-1:0] : trial[hsdc_pkg::DIV_DEN_W-1:0];
      quo_r <= {quo_r[hsdc_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

FILE: hdl/hsdc_tanh_rom.sv
// Constant tanh table with registered reads of two neighboring points.
module hsdc_tanh_rom #(
  parameter int DEPTH = hsdc_pkg::TANH_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic [IDX_W-1:0]             idx,
  output logic [hsdc_pkg::SMP_W-1:0]   lo_r,
  output logic [hsdc_pkg::SMP_W-1:0]   hi_r
);

  typedef logic [hsdc_pkg::SMP_W-1:0] tab_t [DEPTH+1];

  // Shift-and-subtract quotient, evaluated only while the table is built.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], n[j]};
      if (r >= d) begin
        r    = r - d;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // Points of tanh over [0,8]: (1-p)/(1+p) with p = exp(-16/DEPTH)^i in Q30.
  function automatic tab_t build_tab();
    tab_t              t;
    longint unsigned   h;
    longint            b;
    longint unsigned   term;
    longint unsigned   p;
    longint unsigned   nm;
    longint unsigned   dn;
    h    = udiv64(64'd16 << 30, 64'(DEPTH));
    b    = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    p    = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * h) >> 30, 64'(k));
      if ((k & 1) == 1) begin
        b = b - longint'(term);
      end else begin
        b = b + longint'(term);
      end
    end
    if (b < 0) begin
      b = 0;
    end
    for (int i = 0; i <= DEPTH; i++) begin
      nm   = ((64'd1 << 30) - p) << hsdc_pkg::FRAC;
      dn   = (64'd1 << 30) + p;
      t[i] = hsdc_pkg::SMP_W'(udiv64(nm + (dn >> 1), dn));
      p    = (p * longint'(b)) >> 30;
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [IDX_W-1:0] hi_idx;

  // The last point pairs with itself so the top index reads it exactly.
  assign hi_idx = (idx == IDX_W'(DEPTH)) ? idx : idx + 1'b1;

  always_ff @(posedge clk) begin
    lo_r <= TAB[idx];
    hi_r <= TAB[hi_idx];
  end

endmodule

FILE: hdl/harmonic_saturator_dc_block_mix.sv
// A processed item is offered after two passes through the shared divider; one item is in
// flight at a time, so a new item is accepted only after the last one has been taken.
// A disabled block offers the item unchanged the cycle after acceptance
// and keeps the DC state.
// Synchronous active-low reset clears the sequencer, the DC blocker state of every
// channel, and the registers to drive 0, mix full wet, enabled on.
module harmonic_saturator_dc_block_mix #(
  parameter int CHANNELS   = hsdc_pkg::CHANNELS_DEF,
  parameter int TANH_DEPTH = hsdc_pkg::TANH_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [hsdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hsdc_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [hsdc_pkg::SMP_W-1:0]      in_sample_in,
  input  logic                                   in_channel,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [hsdc_pkg::SMP_W-1:0]      out_sample_out
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W = $clog2(TANH_DEPTH + 1);
  localparam int SW    = hsdc_pkg::SMP_W;
  localparam int PW    = hsdc_pkg::PROD_W;
  localparam int AW    = hsdc_pkg::MUL_A_W;
  localparam int BW    = hsdc_pkg::MUL_B_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_GAIN   = 5'd1;
  localparam logic [4:0] S_AREG   = 5'd2;
  localparam logic [4:0] S_POS    = 5'd3;
  localparam logic [4:0] S_IDX    = 5'd4;
  localparam logic [4:0] S_LOOK   = 5'd5;
  localparam logic [4:0] S_INTERP = 5'd6;
  localparam logic [4:0] S_TAN    = 5'd7;
  localparam logic [4:0] S_TMUL   = 5'd8;
  localparam logic [4:0] S_ACC    = 5'd9;
  localparam logic [4:0] S_EWAIT  = 5'd10;
  localparam logic [4:0] S_EMUL   = 5'd11;
  localparam logic [4:0] S_SHAPE  = 5'd12;
  localparam logic [4:0] S_WDIV   = 5'd13;
  localparam logic [4:0] S_WWAIT  = 5'd14;
  localparam logic [4:0] S_DCMUL  = 5'd15;
  localparam logic [4:0] S_DC     = 5'd16;
  localparam logic [4:0] S_MX1    = 5'd17;
  localparam logic [4:0] S_MX2    = 5'd18;
  localparam logic [4:0] S_MIX    = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  // Configuration registers.
  logic [hsdc_pkg::CFG_W-1:0] drive_r;
  logic [hsdc_pkg::CFG_W-1:0] mix_r;
  logic                       enabled_r;

  // Sequencer and datapath registers.
  logic [4:0]            state_r, state_nxt;
  logic signed [SW-1:0]  x_r, x_nxt;
  logic [CH_W-1:0]       ch_r, ch_nxt;
  logic signed [AW-1:0]  a_r, a_nxt;
  logic [AW-1:0]         ua_r, ua_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [15:0]           f_r, f_nxt;
  logic signed [SW:0]    tanh_r, tanh_nxt;
  logic signed [SW:0]    even_r, even_nxt;
  logic signed [PW-1:0]  acc_r, acc_nxt;
  logic signed [SW:0]    shaped_r, shaped_nxt;
  logic signed [SW-1:0]  wet_r, wet_nxt;
  logic signed [SW-1:0]  dc_r, dc_nxt;
  logic signed [SW-1:0]  out_r, out_nxt;
  logic signed [SW-1:0]  w1_r [CHANNELS];
  logic signed [SW-1:0]  y1_r [CHANNELS];
  logic                  dc_we;

  // Shared unit connections.
  logic signed [AW-1:0]                mul_a;
  logic [BW-1:0]                       mul_b;
  logic signed [PW-1:0]                prod_r;
  logic                                div_start;
  logic [hsdc_pkg::DIV_NUM_W-1:0]      div_num;
  logic [hsdc_pkg::DIV_DEN_W-1:0]      div_den;
  logic                                div_busy;
  logic [hsdc_pkg::DIV_NUM_W-1:0]      div_q;
  logic [SW-1:0]                       rom_lo;
  logic [SW-1:0]                       rom_hi;

  // Clamped registers and derived gains.
  logic [hsdc_pkg::CFG_W-1:0] d_cl;
  logic [hsdc_pkg::CFG_W-1:0] m_cl;
  logic [BW-1:0]              gain;

  // Scratch values of the sequencer.
  logic signed [PW-1:0] sh;
  logic [39:0]          pos;
  logic [13:0]          idx_full;
  logic signed [SW:0]   lo_s;
  logic signed [SW:0]   hi_s;
  logic signed [SW:0]   v;
  logic signed [SW+1:0] even_neg;
  logic [SW:0]          shaped_mag;
  logic signed [SW+2:0] wet_s;

  assign d_cl = (drive_r > hsdc_pkg::Q16_ONE) ? hsdc_pkg::Q16_ONE : drive_r;
  assign m_cl = (mix_r > hsdc_pkg::Q16_ONE) ? hsdc_pkg::Q16_ONE : mix_r;
  assign gain = BW'(hsdc_pkg::Q16_ONE) + BW'(d_cl) * BW'(7);

  hsdc_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  hsdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q)
  );

  hsdc_tanh_rom #(
    .DEPTH (TANH_DEPTH),
    .IDX_W (IDX_W)
  ) u_rom (
    .clk  (clk),
    .idx  (idx_r),
    .lo_r (rom_lo),
    .hi_r (rom_hi)
  );

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r   <= '0;
      mix_r     <= hsdc_pkg::Q16_ONE;
      enabled_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        hsdc_pkg::REG_DRIVE:   drive_r   <= cfg_data;
        hsdc_pkg::REG_MIX:     mix_r     <= cfg_data;
        hsdc_pkg::REG_ENABLED: enabled_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: each state sets the shared unit operands and captures a result.
  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    ch_nxt     = ch_r;
    a_nxt      = a_r;
    ua_nxt     = ua_r;
    idx_nxt    = idx_r;
    f_nxt      = f_r;
    tanh_nxt   = tanh_r;
    even_nxt   = even_r;
    acc_nxt    = acc_r;
    shaped_nxt = shaped_r;
    wet_nxt    = wet_r;
    dc_nxt     = dc_r;
    out_nxt    = out_r;
    dc_we      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sh         = prod_r >>> 16;
    pos        = prod_r[39:0];
    idx_full   = pos[39:26];
    lo_s       = $signed({1'b0, rom_lo});
    hi_s       = $signed({1'b0, rom_hi});
    v          = lo_s + $signed(sh[SW:0]);
    even_neg   = $signed({1'b0, div_q[SW-1:0], 1'b0}) - $signed((SW+2)'(1) <<< SW);
    shaped_mag = shaped_r[SW] ? (SW+1)'(-shaped_r) : (SW+1)'(shaped_r);
    wet_s      = shaped_r[SW] ? -$signed({1'b0, div_q[SW+1:0]})
                              : $signed({1'b0, div_q[SW+1:0]});

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt  = in_sample_in;
          ch_nxt = (CHANNELS > 1) ? CH_W'(in_channel) : '0;
          if (enabled_r) begin
            state_nxt = S_GAIN;
          end else begin
            out_nxt   = in_sample_in;
            state_nxt = S_OUT;
          end
        end
      end
      // Apply the drive gain.
      S_GAIN: begin
        mul_a     = AW'(x_r);
        mul_b     = gain;
        state_nxt = S_AREG;
      end
      S_AREG: begin
        a_nxt     = sh[AW-1:0];
        ua_nxt    = sh[PW-1] ? AW'(-sh) : sh[AW-1:0];
        state_nxt = S_POS;
      end
      // Table position, and the even-harmonic divide runs in the background.
      S_POS: begin
        mul_a     = $signed(ua_r);
        mul_b     = BW'(TANH_DEPTH);
        div_start = 1'b1;
        if (a_r[AW-1]) begin
          div_num = hsdc_pkg::DIV_NUM_W'(1) << (2 * hsdc_pkg::FRAC + 1);
          div_den = (hsdc_pkg::DIV_DEN_W'(1) << (hsdc_pkg::FRAC + 1)) + ua_r;
        end else begin
          div_num = hsdc_pkg::DIV_NUM_W'(1) << (2 * hsdc_pkg::FRAC);
          div_den = (hsdc_pkg::DIV_DEN_W'(1) << hsdc_pkg::FRAC) + $unsigned(a_r);
        end
        state_nxt = S_IDX;
      end
      S_IDX: begin
        if (idx_full >= 14'(TANH_DEPTH)) begin
          idx_nxt = IDX_W'(TANH_DEPTH);
          f_nxt   = '0;
        end else begin
          idx_nxt = idx_full[IDX_W-1:0];
          f_nxt   = pos[25:10];
        end
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_INTERP;
      end
      // Linear interpolation between neighboring points.
      S_INTERP: begin
        mul_a     = AW'(hi_s - lo_s);
        mul_b     = BW'(f_r);
        state_nxt = S_TAN;
      end
      S_TAN: begin
        tanh_nxt  = a_r[AW-1] ? -v : v;
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        mul_a     = AW'(tanh_r);
        mul_b     = BW'(hsdc_pkg::C_TANH);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt   = prod_r;
        state_nxt = S_EWAIT;
      end
      // Even-harmonic soft clip from the divider quotient.
      S_EWAIT: begin
        if (!div_busy) begin
          if (a_r[AW-1]) begin
            even_nxt = even_neg[SW:0];
          end else begin
            even_nxt = $signed((SW+1)'(1) <<< hsdc_pkg::FRAC) -
                       $signed({1'b0, div_q[SW-1:0]});
          end
          state_nxt = S_EMUL;
        end
      end
      S_EMUL: begin
        mul_a     = AW'(even_r);
        mul_b     = BW'(hsdc_pkg::C_EVEN);
        state_nxt = S_SHAPE;
      end
      S_SHAPE: begin
        sh         = (acc_r + prod_r) >>> 16;
        shaped_nxt = sh[SW:0];
        mul_a      = $signed(AW'(d_cl));
        mul_b      = BW'(hsdc_pkg::C_DRV_ATT);
        state_nxt  = S_WDIV;
      end
      // Output level compensation divide.
      S_WDIV: begin
        div_start = 1'b1;
        div_num   = hsdc_pkg::DIV_NUM_W'(shaped_mag) << 16;
        div_den   = hsdc_pkg::DIV_DEN_W'(hsdc_pkg::Q16_ONE) +
                    hsdc_pkg::DIV_DEN_W'(prod_r[31:16]);
        state_nxt = S_WWAIT;
      end
      S_WWAIT: begin
        if (!div_busy) begin
          wet_nxt   = hsdc_pkg::sat_smp(PW'(wet_s));
          state_nxt = S_DCMUL;
        end
      end
      // DC blocker for the selected channel.
      S_DCMUL: begin
        mul_a     = AW'(y1_r[ch_r]);
        mul_b     = BW'(hsdc_pkg::C_POLE);
        state_nxt = S_DC;
      end
      S_DC: begin
        dc_nxt    = hsdc_pkg::sat_smp(PW'(wet_r) - PW'(w1_r[ch_r]) + sh);
        dc_we     = 1'b1;
        state_nxt = S_MX1;
      end
      // Dry and wet mix.
      S_MX1: begin
        mul_a     = AW'(x_r);
        mul_b     = BW'(hsdc_pkg::Q16_ONE - m_cl);
        state_nxt = S_MX2;
      end
      S_MX2: begin
        acc_nxt   = prod_r;
        mul_a     = AW'(dc_r);
        mul_b     = BW'(m_cl);
        state_nxt = S_MIX;
      end
      S_MIX: begin
        sh        = (acc_r + prod_r) >>> 16;
        out_nxt   = hsdc_pkg::sat_smp(sh);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // DC blocker history, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        w1_r[c] <= '0;
        y1_r[c] <= '0;
      end
    end else if (dc_we) begin
      w1_r[ch_r] <= wet_r;
      y1_r[ch_r] <= dc_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    ch_r     <= ch_nxt;
    a_r      <= a_nxt;
    ua_r     <= ua_nxt;
    idx_r    <= idx_nxt;
    f_r      <= f_nxt;
    tanh_r   <= tanh_nxt;
    even_r   <= even_nxt;
    acc_r    <= acc_nxt;
    shaped_r <= shaped_nxt;
    wet_r    <= wet_nxt;
    dc_r     <= dc_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_sample_out = out_r;

endmodule

FILE: sim/harmonic_saturator_dc_block_mix_tb.sv
// Self-checking testbench for the harmonic saturator with DC blocker and dry/wet mix.
`timescale 1ns / 100ps

module harmonic_saturator_dc_block_mix_tb;

  localparam int SMP_W          = hsdc_pkg::SMP_W;
  localparam int FRAC           = hsdc_pkg::FRAC;
  localparam int CFG_W          = hsdc_pkg::CFG_W;
  localparam int CFG_IDX_W      = hsdc_pkg::CFG_IDX_W;
  localparam int TANH_DEPTH_DEF = hsdc_pkg::TANH_DEPTH_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE   = hsdc_pkg::REG_DRIVE;
  localparam logic [CFG_IDX_W-1:0] REG_MIX     = hsdc_pkg::REG_MIX;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = hsdc_pkg::REG_ENABLED;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 150;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_DRIVE;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [SMP_W-1:0]  in_sample_in = '0;
  logic                     in_channel = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SMP_W-1:0]  out_sample_out;

  // Predictor copy of the registers and the DC blocker state.
  int                       drive_q;
  int                       mix_q;
  bit                       enabled_q;
  longint                   dc_last_wet [2];
  longint                   dc_last_out [2];
  longint                   tanh_points [TANH_DEPTH_DEF + 1];

  logic signed [SMP_W-1:0]  expected_samples [$];
  int                       mismatches = 0;
  int                       sender_idle_pct = 0;
  int                       stall_pct = 0;
  int                       hold_cycles = 0;
  int                       quiet_cycles = 0;

  harmonic_saturator_dc_block_mix DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_in(in_sample_in), .in_channel(in_channel),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out)
  );

  always #6 clk = ~clk;

  // Build the interpolated tanh table from the Taylor series of exp(-16/depth).
  function automatic void build_tanh_points();
    longint unsigned one30;
    longint unsigned step_h;
    longint unsigned term;
    longint unsigned p;
    longint          b;
    one30  = 64'd1 << 30;
    step_h = (64'd16 << 30) / TANH_DEPTH_DEF;
    term   = one30;
    p      = one30;
    b      = longint'(one30);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * step_h) >> 30) / k;
      if (k % 2 == 1) b -= longint'(term); else b += longint'(term);
    end
    if (b < 0) b = 0;
    for (int i = 0; i <= TANH_DEPTH_DEF; i++) begin
      tanh_points[i] = longint'((((one30 - p) << FRAC) + (one30 + p) / 2) / (one30 + p));
      p = (p * longint'(b)) >> 30;
    end
  endfunction

  function automatic longint clamp_sample(longint v);
    longint hi;
    hi = (64'sd1 <<< FRAC) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Expected output for one item; updates the DC state when enabled.
  function automatic logic signed [SMP_W-1:0] shape_sample(logic signed [SMP_W-1:0] smp,
                                                          logic ch);
    longint x, d, m, a, ua, pos, idx, f, t, ev, shaped, wet, dc, res;
    x = longint'(smp);
    if (!enabled_q) return smp;
    d = (drive_q > 65536) ? 65536 : drive_q;
    m = (mix_q > 65536) ? 65536 : mix_q;
    a = (x * (65536 + 7 * d)) >>> 16;
    ua = (a < 0) ? -a : a;
    pos = ua * TANH_DEPTH_DEF;
    idx = pos >>> (FRAC + 3);
    if (idx >= TANH_DEPTH_DEF) begin
      t = tanh_points[TANH_DEPTH_DEF];
    end else begin
      f = (pos >>> (FRAC + 3 - 16)) & 65535;
      t = tanh_points[idx] + (((tanh_points[idx + 1] - tanh_points[idx]) * f) >>> 16);
    end
    if (a < 0) t = -t;
    // Asymmetric soft clip: the negative side bends half as hard.
    if (a >= 0) begin
      ev = (64'sd1 <<< FRAC) - ((64'sd1 <<< (2 * FRAC)) / ((64'sd1 <<< FRAC) + a));
    end else begin
      ev = -((64'sd1 <<< (FRAC + 1))
             - 2 * ((64'sd1 <<< (2 * FRAC + 1)) / ((64'sd1 <<< (FRAC + 1)) - a)));
    end
    shaped = (45875 * t + 19661 * ev) >>> 16;
    wet = clamp_sample((shaped * 65536) / (65536 + ((d * 52429) >>> 16)));
    dc = clamp_sample(wet - dc_last_wet[ch] + ((65208 * dc_last_out[ch]) >>> 16));
    dc_last_wet[ch] = wet;
    dc_last_out[ch] = dc;
    res = clamp_sample((x * (65536 - m) + dc * m) >>> 16);
    return res[SMP_W-1:0];
  endfunction

  // Receiver: random stalls, or a forced hold-off while hold_cycles runs down.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare every accepted result item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %0d", out_sample_out);
      end else begin
        if (out_sample_out !== expected_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d, got %0d", expected_samples[0], out_sample_out);
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  // Watchdog on cycles where neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one item, with optional idle cycles before it.
  task automatic send_sample(logic signed [SMP_W-1:0] smp, logic ch);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    in_channel   <= ch;
    @(posedge clk iff !in_stall);
    expected_samples.push_back(shape_sample(smp, ch));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the caller has let the block go idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DRIVE) drive_q = val;
    else if (idx == REG_MIX) mix_q = val;
    else if (idx == REG_ENABLED) enabled_q = val[0];
    @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] random_sample();
    if ($urandom_range(3) == 0) return SMP_W'(int'($urandom_range(4095)) - 2048);
    return SMP_W'($urandom);
  endfunction

  task automatic directed_extremes(int drv, int mx);
    wait_idle();
    write_reg(REG_DRIVE, CFG_W'(drv));
    write_reg(REG_MIX, CFG_W'(mx));
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b1);
    send_sample(24'sd0, 1'b0);
    send_sample(-24'sd1, 1'b1);
    send_sample(24'sd1, 1'b1);
  endtask

  // Extremes of the sample at low and full drive, mix ends and over-range values.
  task automatic test_directed();
    directed_extremes(0, 65536);
    directed_extremes(65536, 0);
    directed_extremes(131071, 131071);
    // Disabled block passes items through and keeps the DC state.
    wait_idle();
    write_reg(REG_ENABLED, CFG_W'(0));
    send_sample(24'sh123456, 1'b0);
    send_sample(-24'sh800000, 1'b1);
    wait_idle();
    write_reg(REG_ENABLED, CFG_W'(1));
    // A write to an index past the register list is ignored.
    write_reg(CFG_IDX_W'(3), '1);
    send_sample(24'sh400000, 1'b0);
    send_sample(-24'sh400000, 1'b1);
  endtask

  task automatic test_random_phase(int snd_pct, int rcv_pct, int count);
    int r;
    wait_idle();
    sender_idle_pct = snd_pct;
    stall_pct = rcv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        wait_idle();
        r = $urandom_range(5);
        write_reg(REG_DRIVE, (r == 0) ? CFG_W'(0) : (r == 1) ? CFG_W'(65536)
                                                 : CFG_W'($urandom_range(131071)));
        r = $urandom_range(5);
        write_reg(REG_MIX, (r == 0) ? CFG_W'(0) : (r == 1) ? CFG_W'(65536)
                                               : CFG_W'($urandom_range(131071)));
        write_reg(REG_ENABLED, CFG_W'($urandom_range(7) != 0));
      end
      send_sample(random_sample(), 1'($urandom));
    end
  endtask

  // Long receiver hold-off with the sender pushing, then a full drain.
  task automatic test_backpressure();
    wait_idle();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 600;
    for (int i = 0; i < 12; i++) send_sample(random_sample(), 1'($urandom));
    wait_idle();
    for (int i = 0; i < 8; i++) send_sample(random_sample(), 1'($urandom));
  endtask

  initial begin
    enabled_q = 1'b1;
    drive_q = 0;
    mix_q = 65536;
    for (int c = 0; c < 2; c++) begin
      dc_last_wet[c] = 0;
      dc_last_out[c] = 0;
    end
    build_tanh_points();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(0, 0, 180);
    test_random_phase(76, 0, 180);
    test_random_phase(0, 76, 180);
    test_random_phase(32, 32, 180);
    test_backpressure();

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
